>>> sv/hps_pkg.sv
`timescale 1ns / 1ps

package hps_pkg;

    localparam int unsigned READING_W = 10;
    localparam int unsigned WAIT_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [READING_W-1:0] HOT_THRESHOLD_RST = 10'd892;
    localparam logic [WAIT_W-1:0]    SAMPLE_WAIT_RST   = 16'd100;
    localparam logic [WAIT_W-1:0]    WARMUP_WAIT_RST   = 16'd1300;
    localparam logic [WAIT_W-1:0]    REBOOT_WAIT_RST   = 16'd300;

    localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WAIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_WAIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REBOOT_WAIT   = 2'd3;

    localparam logic [2:0] PH_START    = 3'd0;
    localparam logic [2:0] PH_INTERVAL = 3'd1;
    localparam logic [2:0] PH_WARMUP   = 3'd2;
    localparam logic [2:0] PH_REBOOT   = 3'd3;
    localparam logic [2:0] PH_MONITOR  = 3'd4;
    localparam logic [2:0] PH_RESAMPLE = 3'd5;

    typedef enum logic [5:0] {
        ST_START    = 6'b000001,
        ST_INTERVAL = 6'b000010,
        ST_WARMUP   = 6'b000100,
        ST_REBOOT   = 6'b001000,
        ST_MONITOR  = 6'b010000,
        ST_RESAMPLE = 6'b100000
    } t_phase;

    typedef struct packed {
        logic blue;
        logic red;
        logic heat;
        logic power;
    } t_drive;

    typedef struct packed {
        logic [READING_W-1:0] hot_threshold;
        logic [WAIT_W-1:0]    sample_wait;
        logic [WAIT_W-1:0]    warmup_wait;
        logic [WAIT_W-1:0]    reboot_wait;
    } t_cfg;

    typedef struct packed {
        logic [READING_W-1:0] temperature_sample;
        logic                 sense_level;
        logic                 key_level;
        logic                 key_rise;
        logic                 shutdown_fall;
    } t_item;

    typedef struct packed {
        t_phase               phase;
        logic [READING_W-1:0] latched;
        logic                 hold;
        t_drive               drive;
    } t_state;

    function automatic logic [2:0] phase_code(input t_phase ph);
        logic [2:0] code;
        unique case (ph)
            ST_START:    code = PH_START;
            ST_INTERVAL: code = PH_INTERVAL;
            ST_WARMUP:   code = PH_WARMUP;
            ST_REBOOT:   code = PH_REBOOT;
            ST_MONITOR:  code = PH_MONITOR;
            ST_RESAMPLE: code = PH_RESAMPLE;
            default:     code = PH_INTERVAL;
        endcase
        return code;
    endfunction

endpackage

>>> sv/hps_step.sv
`timescale 1ns / 1ps

module hps_step
    import hps_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  t_cfg                   i_cfg,
    input  t_state                 i_state,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  t_item                  i_item,
    output t_state                 o_state,
    output logic [COUNT_WIDTH-1:0] o_count
);

    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic [COUNT_WIDTH-1:0] sample_load;
    logic [COUNT_WIDTH-1:0] warmup_load;
    logic [COUNT_WIDTH-1:0] reboot_load;
    logic [COUNT_WIDTH-1:0] base_cnt;
    logic                   expire;
    logic                   mon_exit;
    logic [READING_W-1:0]   rd;
    t_state                 st;
    logic [COUNT_WIDTH-1:0] cnt;

    assign sample_load = COUNT_WIDTH'(i_cfg.sample_wait);
    assign warmup_load = COUNT_WIDTH'(i_cfg.warmup_wait);
    assign reboot_load = COUNT_WIDTH'(i_cfg.reboot_wait);

    always_comb begin
        st       = i_state;
        cnt      = i_count;
        rd       = i_item.temperature_sample;
        base_cnt = i_count;
        expire   = 1'b0;
        mon_exit = 1'b0;

        if (i_item.key_rise) begin
            st.drive.heat = 1'b0;
            st.drive.red  = 1'b0;
            st.drive.blue = 1'b1;
            st.hold       = 1'b1;
        end
        if (i_item.shutdown_fall) begin
            st.drive = '0;
        end

        if (i_state.phase != ST_INTERVAL && i_state.phase != ST_START &&
            i_state.phase != ST_WARMUP && i_state.phase != ST_REBOOT &&
            i_state.phase != ST_MONITOR && i_state.phase != ST_RESAMPLE) begin
            base_cnt = sample_load;
        end
        expire = (base_cnt <= CNT_ONE);
        cnt    = expire ? '0 : base_cnt - CNT_ONE;

        unique case (i_state.phase)
            ST_START: begin
                if (expire) begin
                    st.phase = ST_INTERVAL;
                    cnt      = sample_load;
                end
            end
            ST_WARMUP: begin
                if (expire) begin
                    if (!i_item.sense_level) begin
                        st.drive.heat = 1'b0;
                        st.drive.red  = 1'b0;
                        st.drive.blue = 1'b0;
                        st.hold       = 1'b0;
                        st.phase      = ST_INTERVAL;
                        cnt           = sample_load;
                    end else if (!st.hold) begin
                        st.drive = '0;
                        st.phase = ST_REBOOT;
                        cnt      = reboot_load;
                    end else begin
                        st.phase = ST_MONITOR;
                        cnt      = '0;
                    end
                end
            end
            ST_REBOOT: begin
                if (expire) begin
                    st.drive.power = 1'b1;
                    st.phase       = ST_INTERVAL;
                    cnt            = sample_load;
                end
            end
            ST_MONITOR: begin
                cnt      = i_count;
                mon_exit = (i_state.latched > i_cfg.hot_threshold) ||
                           !i_item.key_level || !st.drive.power;
                if (!i_item.sense_level) begin
                    st.drive.heat = 1'b0;
                    st.drive.red  = 1'b0;
                    st.drive.blue = 1'b0;
                    st.hold       = 1'b0;
                    st.latched    = rd;
                    st.phase      = ST_RESAMPLE;
                    cnt           = sample_load;
                end else if (mon_exit) begin
                    st.phase = ST_INTERVAL;
                    cnt      = sample_load;
                end
            end
            ST_RESAMPLE: begin
                if (expire) begin
                    st.latched = rd;
                    mon_exit   = (i_item.sense_level && (rd > i_cfg.hot_threshold)) ||
                                 (!i_item.key_level && i_item.sense_level) ||
                                 !st.drive.power;
                    if (mon_exit) begin
                        st.phase = ST_INTERVAL;
                        cnt      = sample_load;
                    end else begin
                        st.phase = ST_MONITOR;
                        cnt      = '0;
                    end
                end
            end
            default: begin
                st.phase = ST_INTERVAL;
                if (expire) begin
                    st.latched = rd;
                    if (rd > i_cfg.hot_threshold) begin
                        st.drive.power = 1'b0;
                        st.drive.blue  = 1'b0;
                        st.drive.heat  = 1'b1;
                        st.drive.red   = 1'b1;
                        cnt            = sample_load;
                    end else if (rd < i_cfg.hot_threshold) begin
                        st.drive.power = 1'b1;
                        st.phase       = ST_WARMUP;
                        cnt            = warmup_load;
                    end else begin
                        cnt = sample_load;
                    end
                end
            end
        endcase

        o_state = st;
        o_count = cnt;
    end

endmodule

>>> sv/heater_power_sequencer.sv
`timescale 1ns / 1ps

// Heater power sequencer. Each input word is one time tick and yields exactly one
// output word with the drive levels and phase after that tick. One tick is taken
// every clock cycle while o_ready is high; its result reaches the output register
// in the next cycle, since the whole tick update (edge events, one countdown step,
// one threshold compare, phase change) is a single pass of logic ahead of the
// state and output registers. o_ready follows output space: it is high when the
// output register is empty or being taken in the same cycle. Configuration writes
// take effect at once and are meant to be issued while no tick is in flight.
module heater_power_sequencer
    import hps_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WAIT_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [READING_W-1:0] i_temperature_sample,
    input  logic                 i_sense_level,
    input  logic                 i_key_level,
    input  logic                 i_key_rise,
    input  logic                 i_shutdown_fall,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_power_on,
    output logic                 o_heater_on,
    output logic                 o_red_led,
    output logic                 o_blue_led,
    output logic [2:0]           o_phase_now
);

    t_cfg                   r_cfg;
    t_state                 r_state;
    t_state                 n_state;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_out_valid;
    t_drive                 r_out_drive;
    logic [2:0]             r_out_phase;
    t_item                  item;
    logic                   accept;

    assign item = '{
        temperature_sample: i_temperature_sample,
        sense_level:        i_sense_level,
        key_level:          i_key_level,
        key_rise:           i_key_rise,
        shutdown_fall:      i_shutdown_fall
    };

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hot_threshold <= HOT_THRESHOLD_RST;
            r_cfg.sample_wait   <= SAMPLE_WAIT_RST;
            r_cfg.warmup_wait   <= WARMUP_WAIT_RST;
            r_cfg.reboot_wait   <= REBOOT_WAIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HOT_THRESHOLD: r_cfg.hot_threshold <= i_cfg_data[READING_W-1:0];
                CFG_SAMPLE_WAIT:   r_cfg.sample_wait   <= i_cfg_data;
                CFG_WARMUP_WAIT:   r_cfg.warmup_wait   <= i_cfg_data;
                CFG_REBOOT_WAIT:   r_cfg.reboot_wait   <= i_cfg_data;
            endcase
        end
    end

    hps_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_count (r_count),
        .i_item  (item),
        .o_state (n_state),
        .o_count (n_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= ST_START;
            r_state.latched <= '0;
            r_state.hold    <= 1'b0;
            r_state.drive   <= '0;
            r_count         <= COUNT_WIDTH'(SAMPLE_WAIT_RST);
            r_out_valid     <= 1'b0;
            r_out_drive     <= '0;
            r_out_phase     <= PH_START;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_count     <= n_count;
                r_out_drive <= n_state.drive;
                r_out_phase <= phase_code(n_state.phase);
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_power_on  = r_out_drive.power;
    assign o_heater_on = r_out_drive.heat;
    assign o_red_led   = r_out_drive.red;
    assign o_blue_led  = r_out_drive.blue;
    assign o_phase_now = r_out_phase;

`ifndef SYNTH
    a_monitor_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == ST_MONITOR |-> r_count == '0)
        else $error("monitor phase with a running countdown");

    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted tick produced no output word");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_phase == phase_code(r_state.phase) &&
                         r_out_drive == r_state.drive))
        else $error("output word out of step with sequencer state");

    a_hold_set_by_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.hold && !$past(r_state.hold)) |-> $past(accept && i_key_rise))
        else $error("hold flag set without a key rise");
`endif

endmodule
